### hdl/dasd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dasd_pkg;

  // operand and result widths
  localparam int unsigned OP_W   = 63;
  localparam int unsigned BIN_W  = OP_W + 1;
  localparam int unsigned DIGITS = 20;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned BCD_W  = DIGIT_W * DIGITS;

  // controller counters
  localparam int unsigned CONV_CW = $clog2(BIN_W);
  localparam int unsigned DIG_CW  = $clog2(DIGITS + 1);

  localparam logic OPC_ADD = 1'b0;
  localparam logic OPC_SUB = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } dasd_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv;
    logic pop;
  } dasd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic top_zero;
  } dasd_stat_t;

endpackage
`default_nettype wire

### hdl/dasd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dasd_in_if;
  import dasd_pkg::*;

  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operand_a;
  logic [OP_W-1:0] operand_b;
  logic            opcode;

  modport source (output valid, output operand_a, output operand_b, output opcode,
                  input ready);
  modport sink   (input valid, input operand_a, input operand_b, input opcode,
                  output ready);
endinterface
`default_nettype wire

### hdl/dasd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dasd_out_if;
  import dasd_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               negative;
  logic               last;

  modport source (output valid, output digit, output negative, output last,
                  input ready);
  modport sink   (input valid, input digit, input negative, input last,
                  output ready);
endinterface
`default_nettype wire

### hdl/dasd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module dasd_datapath
  import dasd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic [OP_W-1:0]    operand_a_i,
  input  wire logic [OP_W-1:0]    operand_b_i,
  input  wire logic               opcode_i,
  input  wire dasd_cmd_t          cmd_i,
  output dasd_stat_t              stat_o,
  output logic [DIGIT_W-1:0]      digit_o,
  output logic                    negative_o
);

  logic [BIN_W-1:0] a_ext, b_ext, sum, diff_ab, diff_ba, mag;
  logic             lt;

  logic [BIN_W-1:0] bin_d, bin_q;
  logic [BCD_W-1:0] bcd_d, bcd_q, bcd_adj;
  logic             neg_d, neg_q;

  // magnitude and sign of the binary result
  always_comb begin
    a_ext   = {1'b0, operand_a_i};
    b_ext   = {1'b0, operand_b_i};
    sum     = a_ext + b_ext;
    diff_ab = a_ext - b_ext;
    diff_ba = b_ext - a_ext;
    lt      = (opcode_i == OPC_SUB) && diff_ab[BIN_W-1];
    if (opcode_i == OPC_ADD) begin
      mag = sum;
    end else if (lt) begin
      mag = diff_ba;
    end else begin
      mag = diff_ab;
    end
  end

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      if (bcd_q[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[k*DIGIT_W +: DIGIT_W] = bcd_q[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[k*DIGIT_W +: DIGIT_W] = bcd_q[k*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    neg_d = neg_q;
    if (cmd_i.load) begin
      bin_d = mag;
      bcd_d = '0;
      neg_d = lt;
    end else if (cmd_i.conv) begin
      bin_d = {bin_q[BIN_W-2:0], 1'b0};
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
    end else if (cmd_i.pop) begin
      bcd_d = {bcd_q[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign digit_o         = bcd_q[BCD_W-1 -: DIGIT_W];
  assign negative_o      = neg_q;
  assign stat_o.top_zero = (digit_o == DIGIT_W'(0));

endmodule
`default_nettype wire

### hdl/dasd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module dasd_ctrl
  import dasd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            last_o,
  input  wire dasd_stat_t stat_i,
  output dasd_cmd_t       cmd_o
);

  dasd_state_e        state_d, state_q;
  logic [CONV_CW-1:0] conv_d, conv_q;
  logic [DIG_CW-1:0]  left_d, left_q;
  logic               one_left;

  assign one_left    = (left_q == DIG_CW'(1));
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign last_o      = one_left;

  always_comb begin
    state_d = state_q;
    conv_d  = conv_q;
    left_d  = left_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          conv_d     = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        conv_d     = conv_q + CONV_CW'(1);
        if (conv_q == CONV_CW'(BIN_W - 1)) begin
          left_d  = DIG_CW'(DIGITS);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (stat_i.top_zero && !one_left) begin
          cmd_o.pop = 1'b1;
          left_d    = left_q - DIG_CW'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          cmd_o.pop = 1'b1;
          left_d    = left_q - DIG_CW'(1);
          if (one_left) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      conv_q  <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      conv_q  <= conv_d;
      left_q  <= left_d;
    end
  end

endmodule
`default_nettype wire

### hdl/decimal_add_subtract_digits_core.sv
`timescale 1ns / 1ps
`default_nettype none
// decimal add / subtract: takes two 63-bit unsigned operands and an opcode
// (add, or subtract giving magnitude and sign), and returns the decimal
// digits of the result, one digit per output beat, most significant first,
// leading zeros suppressed (a zero result gives one 0 digit); negative is
// set on every digit of a subtraction whose first operand is the smaller,
// last marks the least significant digit. one operation is in flight at a
// time: the input beat is taken, then shift-and-add-3 conversion runs (one
// binary bit per cycle), then the suppressed leading zeros are dropped, the
// skip state hands over to emission, and the digits are emitted while the
// sink is ready; suppressed zeros and emitted digits always add up to 20,
// and the sink holding ready low during emission stalls the output
module decimal_add_subtract_digits_core
  import dasd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dasd_in_if.sink   in_i,
  dasd_out_if.source out_o
);

  dasd_cmd_t  cmd;
  dasd_stat_t stat;

  // sequencer: load, conversion count, zero skipping, digit emission
  dasd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .last_o      (out_o.last),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // binary sum / difference, then the bcd shift register
  dasd_datapath u_datapath (
    .clk_i       (clk_i),
    .operand_a_i (in_i.operand_a),
    .operand_b_i (in_i.operand_b),
    .opcode_i    (in_i.opcode),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .digit_o     (out_o.digit),
    .negative_o  (out_o.negative)
  );

endmodule
`default_nettype wire

### hdl/dasd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module dasd_checker
  import dasd_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [DIGIT_W-1:0] digit_i,
  input wire logic               negative_i,
  input wire logic               last_i
);

  // a stalled digit beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(digit_i)
      && $stable(negative_i) && $stable(last_i))
    else $error("stalled output beat changed");

  // busy after an input beat is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // no input taken while digits are still going out
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready during emission");

  // a decimal digit only
  a_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> digit_i <= DIGIT_W'(9))
    else $error("digit out of range");

  // digits of one result follow each other until last
  a_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i && $stable(negative_i))
    else $error("result broken before last digit");

endmodule

bind decimal_add_subtract_digits_core dasd_checker u_dasd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .digit_i     (out_o.digit),
  .negative_i  (out_o.negative),
  .last_i      (out_o.last)
);
`default_nettype wire

### dv/dasd_digit_checker.sv
`timescale 1ns / 1ps
module dasd_digit_checker
  import dasd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  dasd_in_if   in_mon_i,
  dasd_out_if  out_mon_i,
  output int   fail_count_o,
  output int   due_count_o,
  output int   beats_checked_o
);

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               negative;
    logic               last;
  } digit_beat_t;

  digit_beat_t digits_due[$];

  // decimal digit-serial add / subtract, digits queued most significant first
  task automatic queue_result_digits(input logic [OP_W-1:0] a_in,
                                     input logic [OP_W-1:0] b_in,
                                     input logic            opc_in);
    logic [63:0]        va;
    logic [63:0]        vb;
    logic [DIGIT_W-1:0] da[DIGITS];
    logic [DIGIT_W-1:0] db[DIGITS];
    logic [DIGIT_W-1:0] dr[DIGITS];
    int unsigned        x;
    int unsigned        y;
    int unsigned        s;
    int unsigned        carry;
    int                 top;
    logic               is_sub;
    logic               neg;
    digit_beat_t        beat;
    is_sub = (opc_in == OPC_SUB);
    neg    = is_sub && (a_in < b_in);
    va     = neg ? {1'b0, b_in} : {1'b0, a_in};
    vb     = neg ? {1'b0, a_in} : {1'b0, b_in};
    carry  = 0;
    top    = 0;
    for (int k = 0; k < DIGITS; k++) begin
      da[k] = DIGIT_W'(va % 10);
      db[k] = DIGIT_W'(vb % 10);
      va    = va / 10;
      vb    = vb / 10;
    end
    for (int k = 0; k < DIGITS; k++) begin
      if (!is_sub) begin
        s     = da[k] + db[k] + carry;
        carry = (s >= 10) ? 1 : 0;
        dr[k] = DIGIT_W'(s - carry * 10);
      end else begin
        x = da[k];
        y = db[k] + carry;
        if (x < y) begin
          dr[k] = DIGIT_W'(x + 10 - y);
          carry = 1;
        end else begin
          dr[k] = DIGIT_W'(x - y);
          carry = 0;
        end
      end
    end
    // highest nonzero digit; a zero result keeps the single units digit
    for (int k = 1; k < DIGITS; k++) begin
      if (dr[k] != 0) top = k;
    end
    for (int k = top; k >= 0; k--) begin
      beat.digit    = dr[k];
      beat.negative = neg;
      beat.last     = (k == 0);
      digits_due.push_back(beat);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digit_beat_t want;
    digit_beat_t got;
    if (!rst_ni) begin
      digits_due.delete();
      fail_count_o    <= 0;
      due_count_o     <= 0;
      beats_checked_o <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        queue_result_digits(in_mon_i.operand_a, in_mon_i.operand_b, in_mon_i.opcode);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.digit    = out_mon_i.digit;
        got.negative = out_mon_i.negative;
        got.last     = out_mon_i.last;
        beats_checked_o <= beats_checked_o + 1;
        if (digits_due.size() == 0) begin
          $display("%0t: unexpected digit beat, got digit %0d negative %0b last %0b",
                   $time, got.digit, got.negative, got.last);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = digits_due.pop_front();
          if (got.digit !== want.digit || got.negative !== want.negative ||
              got.last !== want.last) begin
            $display("%0t: mismatch, expected digit %0d negative %0b last %0b, got digit %0d negative %0b last %0b",
                     $time, want.digit, want.negative, want.last,
                     got.digit, got.negative, got.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      due_count_o <= digits_due.size();
    end
  end

endmodule

### dv/tb_decimal_add_subtract_digits_core.sv
`timescale 1ns / 1ps
module tb_decimal_add_subtract_digits_core;
  import dasd_pkg::*;

  typedef logic [OP_W-1:0] operand_t;

  localparam operand_t OPND_MAX = {OP_W{1'b1}};
  localparam int       N_RANDOM = 160;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   due_count;
  int   beats_checked;
  int   ops_sent;
  int   directed_ops;

  dasd_in_if  in_ch ();
  dasd_out_if out_ch ();

  decimal_add_subtract_digits_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // watches both channels, predicts and compares every digit beat
  dasd_digit_checker checker_u (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon_i        (in_ch),
    .out_mon_i       (out_ch),
    .fail_count_o    (fail_count),
    .due_count_o     (due_count),
    .beats_checked_o (beats_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // mostly back to back or short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 100);
  endfunction

  function automatic logic [63:0] pow10(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  // operand shapes that stress carry and borrow chains as well as plain noise
  function automatic operand_t pick_operand();
    logic [63:0] raw;
    int          k;
    raw = {$urandom, $urandom};
    k   = $urandom_range(0, 18);
    case ($urandom_range(0, 6))
      0: return operand_t'(raw);
      1: return operand_t'($urandom_range(0, 999));
      2: return operand_t'(pow10(k) + $urandom_range(0, 20));
      3: return operand_t'(pow10(k) - $urandom_range(1, 20));
      4: return OPND_MAX - operand_t'($urandom_range(0, 50));
      5: return operand_t'(raw) >> $urandom_range(0, 62);
      default: return operand_t'(raw);
    endcase
  endfunction

  // reset, asserted once at the start
  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // one input beat; valid stays high across back-to-back beats
  task automatic send_op(input operand_t a, input operand_t b, input logic opc);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    in_ch.opcode    <= opc;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    ops_sent++;
  endtask

  // sink side: bursts of ready with random stalls between them
  initial begin
    int on_len;
    int off_len;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      on_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(1, 30);
      off_len = idle_len();
      out_ch.ready <= 1'b1;
      repeat (on_len) @(posedge clk_i);
      if (off_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (off_len) @(posedge clk_i);
      end
    end
  end

  // source side: directed corners, then random mix, then drain and verdict
  initial begin
    operand_t a;
    operand_t b;
    logic     opc;
    ops_sent = 0;
    in_ch.valid     <= 1'b0;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    in_ch.opcode    <= OPC_ADD;
    @(posedge rst_ni);
    @(posedge clk_i);

    // zero results from both operations
    send_op('0, '0, OPC_ADD);
    send_op('0, '0, OPC_SUB);
    send_op(operand_t'(7), operand_t'(7), OPC_SUB);
    send_op(OPND_MAX, OPND_MAX, OPC_SUB);
    // widest operands, twenty-digit sum
    send_op(OPND_MAX, OPND_MAX, OPC_ADD);
    send_op(OPND_MAX, '0, OPC_ADD);
    send_op(OPND_MAX, '0, OPC_SUB);
    send_op('0, OPND_MAX, OPC_SUB);
    send_op(OPND_MAX, OPND_MAX - 1, OPC_SUB);
    send_op(OPND_MAX - 1, OPND_MAX, OPC_SUB);
    // sign of small subtractions
    send_op(operand_t'(1), operand_t'(2), OPC_SUB);
    send_op(operand_t'(2), operand_t'(1), OPC_SUB);
    // single digit carry, carry ripple across all nines, borrow ripple
    send_op(operand_t'(9), operand_t'(1), OPC_ADD);
    send_op(operand_t'(5), operand_t'(5), OPC_ADD);
    send_op(operand_t'(123), operand_t'(456), OPC_ADD);
    send_op(operand_t'(pow10(18) - 1), operand_t'(1), OPC_ADD);
    send_op(operand_t'(pow10(18)), operand_t'(1), OPC_SUB);
    send_op(operand_t'(1), operand_t'(pow10(18)), OPC_SUB);
    send_op(operand_t'(pow10(18) * 9), operand_t'(pow10(18) * 9), OPC_ADD);
    // alternating bit patterns
    send_op(operand_t'({(OP_W+1)/2{2'b10}}), operand_t'({(OP_W+1)/2{2'b01}}), OPC_ADD);
    send_op(operand_t'({(OP_W+1)/2{2'b01}}), operand_t'({(OP_W+1)/2{2'b10}}), OPC_SUB);
    directed_ops = ops_sent;

    for (int n = 0; n < N_RANDOM; n++) begin
      a   = pick_operand();
      opc = $urandom_range(0, 1) ? OPC_SUB : OPC_ADD;
      // near-equal pairs hit sign flips and long borrow runs
      if ($urandom_range(0, 3) == 0) begin
        b = a + operand_t'($urandom_range(0, 8)) - operand_t'($urandom_range(0, 8));
      end else begin
        b = pick_operand();
      end
      send_op(a, b, opc);
    end
    in_ch.valid <= 1'b0;

    // let the last prediction land, then wait for every digit and a margin
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    $display("ran %0d operations (%0d directed: zero, carry and borrow ripple, sign, widest)",
             ops_sent, directed_ops);
    $display("checked %0d digit beats against the predicted decimal results", beats_checked);
    if (fail_count == 0 && due_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit, well past the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout with %0d digits outstanding", due_count);
    $display("== FAIL ==");
    $finish;
  end

endmodule
